### hw/rtl/ppm_pkg.sv
// shared constants, types and register codes for the payload pattern matcher
package ppm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int LEN_W       = 6;
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 64;
   localparam int NUM_WORDS   = 4;
   localparam int PAT_BYTES   = NUM_WORDS * WORD_W / BYTE_W;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_WORD_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_WORD_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_WORD_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_WORD_3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 3'd4;

   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [BYTE_W-1:0] byte_type;

   typedef struct packed {
      logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern;
      len_type                          length;
   } cfg_type;

   typedef struct packed {
      logic done;
      logic found;
   } verdict_type;

endpackage

### hw/rtl/ppm_if.sv
// handshake channels of the payload pattern matcher
interface ppm_req_if import ppm_pkg::*; ;
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ppm_rsp_if;
   logic valid;
   logic ready;
   logic found;

   modport source (output valid, output found, input ready);
   modport sink (input valid, input found, output ready);
endinterface

interface ppm_csr_if import ppm_pkg::*; ;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [WORD_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/ppm_csr.sv
// pattern and length registers with length clamping
module ppm_csr import ppm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ppm_csr_if.sink   csr_bus,
   output cfg_type   cfg
);

   logic [NUM_WORDS-1:0][WORD_W-1:0] words_ff, words_in;
   len_type                          len_ff, len_in;
   logic                             wr_en;

   assign csr_bus.ready = 1'b1;
   assign wr_en         = csr_bus.valid && csr_bus.ready;

   always_comb begin
      words_in = words_ff;
      len_in   = len_ff;
      if (wr_en) begin
         unique case (csr_bus.index)
            CSR_PATTERN_WORD_0: words_in[0] = csr_bus.data;
            CSR_PATTERN_WORD_1: words_in[1] = csr_bus.data;
            CSR_PATTERN_WORD_2: words_in[2] = csr_bus.data;
            CSR_PATTERN_WORD_3: words_in[3] = csr_bus.data;
            CSR_PATTERN_LENGTH: len_in = csr_bus.data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= '0;
         len_ff   <= len_type'(1);
      end else begin
         words_ff <= words_in;
         len_ff   <= len_in;
      end
   end

   // zero length acts as one, overlong acts as the maximum
   always_comb begin
      cfg.pattern = words_ff;
      if (len_ff == '0) begin
         cfg.length = len_type'(1);
      end else if (len_ff > len_type'(MAX_PATTERN)) begin
         cfg.length = len_type'(MAX_PATTERN);
      end else begin
         cfg.length = len_ff;
      end
   end

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      cfg.length != '0 && cfg.length <= len_type'(MAX_PATTERN))
      else $error("effective pattern length out of range");

   a_len_write: assert property (@(posedge clock) disable iff (reset)
      wr_en && csr_bus.index == CSR_PATTERN_LENGTH
      |=> len_ff == $past(csr_bus.data[LEN_W-1:0]))
      else $error("pattern length write lost");

endmodule

### hw/rtl/ppm_scan.sv
// input register, byte history and parallel window compare
module ppm_scan import ppm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   ppm_req_if.sink      req_bus,
   input  cfg_type      cfg,
   input  logic         out_free,
   output verdict_type  verdict
);

   logic                                in_valid_ff, in_valid_in;
   byte_type                            in_byte_ff;
   logic                                in_last_ff;
   logic [MAX_PATTERN-1:0][BYTE_W-1:0]  hist_ff;
   logic [MAX_PATTERN-1:0][BYTE_W-1:0]  window;
   logic [MAX_PATTERN-1:0][BYTE_W-1:0]  rev_pat;
   logic [MAX_PATTERN-1:0][BYTE_W-1:0]  aligned;
   logic [MAX_PATTERN-1:0]              pos_ok;
   len_type                             seen_ff, seen_in, seen_next;
   logic                                match_ff, match_in;
   len_type                             shift;
   logic                                hit;
   logic                                advance;
   logic                                req_fire;

   assign advance       = in_valid_ff && (!in_last_ff || out_free);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // newest byte in slot zero
   always_comb begin
      window[0] = in_byte_ff;
      for (int j = 1; j < MAX_PATTERN; j++) begin
         window[j] = hist_ff[j-1];
      end
   end

   // pattern byte k must sit length-1-k slots back: reverse, then slide down
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         rev_pat[i] = cfg.pattern[MAX_PATTERN-1-i];
      end
   end

   assign shift   = len_type'(MAX_PATTERN) - cfg.length;
   assign aligned = rev_pat >> {shift, 3'b000};

   always_comb begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         pos_ok[j] = (len_type'(j) >= cfg.length) || (window[j] == aligned[j]);
      end
   end

   assign seen_next = (seen_ff == len_type'(MAX_PATTERN)) ? seen_ff : seen_ff + len_type'(1);
   assign hit       = (&pos_ok) && (seen_next >= cfg.length);

   always_comb begin
      seen_in  = seen_ff;
      match_in = match_ff;
      if (advance) begin
         if (in_last_ff) begin
            seen_in  = '0;
            match_in = 1'b0;
         end else begin
            seen_in  = seen_next;
            match_in = match_ff || hit;
         end
      end
   end

   assign verdict.done  = advance && in_last_ff;
   assign verdict.found = match_ff || hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         seen_ff     <= '0;
         match_ff    <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         seen_ff     <= seen_in;
         match_ff    <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_bus.data_byte;
         in_last_ff <= req_bus.last_byte;
      end
      if (advance) begin
         hist_ff <= window;
      end
   end

   a_seen_sat: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= len_type'(MAX_PATTERN))
      else $error("history fill count past maximum");

   a_payload_restart: assert property (@(posedge clock) disable iff (reset)
      verdict.done |=> seen_ff == '0 && !match_ff)
      else $error("match state not cleared at payload end");

endmodule

### hw/rtl/ppm_result.sv
// result register holding the found flag until taken
module ppm_result import ppm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  verdict_type  verdict,
   output logic         out_free,
   ppm_rsp_if.source    rsp_bus
);

   logic rsp_valid_ff, rsp_valid_in;
   logic found_ff;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      if (verdict.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (verdict.done) begin
         found_ff <= verdict.found;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.found = found_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      verdict.done |-> !rsp_valid_ff || rsp_bus.ready)
      else $error("pending result overwritten");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      verdict.done |=> rsp_valid_ff && found_ff == $past(verdict.found))
      else $error("result not loaded");

endmodule

### hw/rtl/payload_pattern_matcher.sv
// top level: streaming pattern search over payload bytes
// order: a last byte waits in the input register until the result register is free, then loads it and goes valid
// throughput: one byte per cycle while no last byte waits on a pending result; the compare of the full 32-byte window
//   against the aligned pattern sits between the input and result registers
// reset: synchronous, active high; pattern words clear, length goes to one,
//   fill count and match flag clear, no pending transactions
module payload_pattern_matcher import ppm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   ppm_req_if.sink    req_bus,
   ppm_rsp_if.source  rsp_bus,
   ppm_csr_if.sink    csr_bus
);

   cfg_type     cfg;
   verdict_type verdict;
   logic        out_free;

   ppm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   ppm_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .cfg      (cfg),
      .out_free (out_free),
      .verdict  (verdict)
   );

   ppm_result u_result (
      .clock    (clock),
      .reset    (reset),
      .verdict  (verdict),
      .out_free (out_free),
      .rsp_bus  (rsp_bus)
   );

endmodule

### tb/tb_payload_pattern_matcher.sv
// testbench for the payload pattern matcher: directed and random payloads checked by a search predictor
`timescale 1ns / 1ps

module tb_payload_pattern_matcher;
   import ppm_pkg::*;

   localparam int          BYTES_PER_WORD = WORD_W / BYTE_W;
   localparam int          CSR_INDEX_TOP  = (1 << CSR_INDEX_W) - 1;
   localparam int          RANDOM_BYTES   = 1850;
   localparam int          SETTLE_CYCLES  = 6;
   localparam int          REPORT_LIMIT   = 40;
   localparam longint      RUN_LIMIT_NS   = 64'd20_000_000;

   logic clock;
   logic reset;

   ppm_req_if req_bus ();
   ppm_rsp_if rsp_bus ();
   ppm_csr_if csr_bus ();

   payload_pattern_matcher dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // search predictor state
   byte_type          recent [MAX_PATTERN];
   int                history_fill;
   logic              match_in_payload;
   logic [WORD_W-1:0] pattern_words [NUM_WORDS];
   len_type           pattern_length_reg;

   logic expected_found [$];

   bit sender_idles;
   bit receiver_stalls;
   int fail_count;
   int bytes_sent;
   int payloads_sent;
   int flags_checked;
   int flags_set;
   int settings_loaded;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int active_length();
      int n;
      n = pattern_length_reg;
      if (n == 0) n = 1;
      if (n > MAX_PATTERN) n = MAX_PATTERN;
      return n;
   endfunction

   function automatic byte_type pattern_at(input int k);
      logic [WORD_W-1:0] w;
      w = pattern_words[k / BYTES_PER_WORD];
      return w[(k % BYTES_PER_WORD)*BYTE_W +: BYTE_W];
   endfunction

   function automatic void clear_search_state();
      for (int i = 0; i < MAX_PATTERN; i++) recent[i] = '0;
      history_fill       = 0;
      match_in_payload   = 1'b0;
      for (int w = 0; w < NUM_WORDS; w++) pattern_words[w] = '0;
      pattern_length_reg = len_type'(1);
   endfunction

   function automatic void predict_found(input byte_type value, input logic is_last);
      int   n;
      logic hit;
      n = active_length();
      for (int i = MAX_PATTERN - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = value;
      if (history_fill < MAX_PATTERN) history_fill++;
      if (history_fill >= n) begin
         hit = 1'b1;
         // pattern byte k lies n-1-k places back in the history
         for (int k = 0; k < n; k++) begin
            if (recent[n-1-k] != pattern_at(k)) hit = 1'b0;
         end
         if (hit) match_in_payload = 1'b1;
      end
      if (is_last) begin
         expected_found.push_back(match_in_payload);
         history_fill     = 0;
         match_in_payload = 1'b0;
      end
   endfunction

   function automatic int pick_gap(input bit enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_byte(input byte_type value, input logic is_last);
      int gap;
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= value;
      req_bus.last_byte <= is_last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_found(value, is_last);
      bytes_sent++;
      if (is_last) payloads_sent++;
      @(negedge clock);
      gap = pick_gap(sender_idles);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_payload(input byte_type payload [$]);
      for (int i = 0; i < payload.size(); i++) begin
         send_byte(payload[i], i == payload.size() - 1);
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [WORD_W-1:0] value,
                            input bit more);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_PATTERN_WORD_0: pattern_words[0] = value;
         CSR_PATTERN_WORD_1: pattern_words[1] = value;
         CSR_PATTERN_WORD_2: pattern_words[2] = value;
         CSR_PATTERN_WORD_3: pattern_words[3] = value;
         CSR_PATTERN_LENGTH: pattern_length_reg = value[LEN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      if (!more) csr_bus.valid <= 1'b0;
   endtask

   task automatic load_pattern(input logic [WORD_W-1:0] words [NUM_WORDS],
                               input logic [WORD_W-1:0] length_value);
      write_csr(CSR_PATTERN_WORD_0, words[0], 1'b1);
      write_csr(CSR_PATTERN_WORD_1, words[1], 1'b1);
      write_csr(CSR_PATTERN_WORD_2, words[2], 1'b1);
      write_csr(CSR_PATTERN_WORD_3, words[3], 1'b1);
      write_csr(CSR_PATTERN_LENGTH, length_value, 1'b0);
      settings_loaded++;
   endtask

   // config may only change once every result is out and the pipe is empty
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (expected_found.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // reset pattern is one zero byte
   task automatic test_reset_defaults();
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      send_payload('{8'h00});
      send_payload('{8'hFF});
      send_payload('{8'h12, 8'h00, 8'h34});
   endtask

   task automatic test_payload_boundaries();
      logic [WORD_W-1:0] words [NUM_WORDS];
      words[0] = 64'h0000_0000_0000_FF00;
      words[1] = '0;
      words[2] = '1;
      words[3] = '1;
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      drain_results();
      load_pattern(words, 64'd2);
      send_payload('{8'hFF, 8'h00, 8'hFF});
      // payload shorter than the pattern
      send_payload('{8'h00});
      // pattern split over two payloads must not match
      send_payload('{8'hFF, 8'h00});
      send_payload('{8'hFF});
   endtask

   task automatic test_register_corners();
      drain_results();
      // writes to unused indexes leave the pattern alone
      for (int idx = CSR_PATTERN_LENGTH + 1; idx <= CSR_INDEX_TOP; idx++) begin
         write_csr(idx[CSR_INDEX_W-1:0], '1, idx != CSR_INDEX_TOP);
      end
      send_payload('{8'h00, 8'hFF});
      // zero length acts as a single byte
      drain_results();
      write_csr(CSR_PATTERN_LENGTH, '0, 1'b0);
      send_payload('{8'hFF, 8'hFF});
      send_payload('{8'hFF, 8'h00});
      // all-ones value masks to 63, which clamps to the full window
      drain_results();
      write_csr(CSR_PATTERN_LENGTH, '1, 1'b0);
      send_payload('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00});
   endtask

   function automatic byte_type filler_byte(input bit near);
      if (near && $urandom_range(0, 1) == 1) return pattern_at($urandom_range(0, active_length() - 1));
      if ($urandom_range(0, 15) == 0) return 8'h00;
      return byte_type'($urandom_range(0, 255));
   endfunction

   task automatic test_random_search();
      logic [WORD_W-1:0] words [NUM_WORDS];
      logic [WORD_W-1:0] length_value;
      byte_type          payload [$];
      byte_type          carry [$];
      byte_type          sym_a, sym_b, b;
      int                style, r, enc, eff, plen, off, cut, pos, random_bytes;
      bit                near;
      random_bytes = 0;
      while (random_bytes < RANDOM_BYTES) begin
         drain_results();
         sender_idles    = ($urandom_range(0, 3) != 0);
         receiver_stalls = ($urandom_range(0, 3) != 0);

         style = $urandom_range(0, 9);
         sym_a = byte_type'($urandom_range(0, 255));
         sym_b = byte_type'($urandom_range(0, 255));
         for (int i = 0; i < PAT_BYTES; i++) begin
            if (style < 6)      b = byte_type'($urandom_range(0, 255));
            else if (style < 9) b = ($urandom_range(0, 1) == 1) ? sym_a : sym_b;
            else                b = 8'h00;
            words[i / BYTES_PER_WORD][(i % BYTES_PER_WORD)*BYTE_W +: BYTE_W] = b;
         end
         r = $urandom_range(0, 99);
         if (r < 10)      enc = 1;
         else if (r < 20) enc = MAX_PATTERN;
         else if (r < 25) enc = 0;
         else if (r < 30) enc = $urandom_range(MAX_PATTERN + 1, (1 << LEN_W) - 1);
         else if (r < 75) enc = $urandom_range(2, 6);
         else             enc = $urandom_range(7, MAX_PATTERN - 1);
         // junk in the upper bits must be masked off
         length_value = {$urandom, $urandom};
         if ($urandom_range(0, 1) == 0) length_value = '0;
         length_value[LEN_W-1:0] = enc[LEN_W-1:0];
         if ($urandom_range(0, 4) == 0) begin
            write_csr(CSR_INDEX_W'($urandom_range(CSR_PATTERN_LENGTH + 1, CSR_INDEX_TOP)),
                      {$urandom, $urandom}, 1'b1);
         end
         load_pattern(words, length_value);

         eff = active_length();
         near = ($urandom_range(0, 1) == 1);
         carry.delete();
         repeat ($urandom_range(4, 10)) begin
            r = $urandom_range(0, 99);
            if (r < 10)      plen = $urandom_range(1, 3);
            else if (r < 80) plen = $urandom_range(1, eff + 20);
            else             plen = $urandom_range(eff, eff + 60);
            payload = carry;
            carry.delete();
            while (payload.size() < plen) payload.push_back(filler_byte(near));
            r = $urandom_range(0, 99);
            if (r < 70 && payload.size() >= eff) begin
               off = $urandom_range(0, payload.size() - eff);
               for (int k = 0; k < eff; k++) payload[off + k] = pattern_at(k);
               // near miss: one byte off
               if (r >= 55) begin
                  pos = $urandom_range(0, eff - 1);
                  payload[off + pos] = payload[off + pos] ^ byte_type'($urandom_range(1, 255));
               end
            end else if (r < 85 && eff > 1) begin
               // pattern head ends this payload, tail starts the next one
               cut = $urandom_range(1, eff - 1);
               for (int k = 0; k < cut; k++) payload.push_back(pattern_at(k));
               for (int k = cut; k < eff; k++) carry.push_back(pattern_at(k));
            end
            send_payload(payload);
            random_bytes += payload.size();
            if (random_bytes >= RANDOM_BYTES) break;
         end
      end
      drain_results();
   endtask

   // result checker
   always @(posedge clock) begin
      logic want_found;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         flags_checked++;
         if (rsp_bus.found) flags_set++;
         if (expected_found.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("%0t: found flag with no payload pending: expected none, actual %0b",
                        $time, rsp_bus.found);
         end else begin
            want_found = expected_found.pop_front();
            if (rsp_bus.found !== want_found) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: found mismatch: expected %0b, actual %0b",
                           $time, want_found, rsp_bus.found);
            end
         end
      end
   end

   // result-side backpressure
   initial begin
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (receiver_stalls && $urandom_range(0, 99) < 35) begin
               stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                        : $urandom_range(1, 3);
            end
         end
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("%0t: run did not finish in time, %0d flags still pending",
               $time, expected_found.size());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      sender_idles      = 1'b0;
      receiver_stalls   = 1'b0;
      fail_count        = 0;
      bytes_sent        = 0;
      payloads_sent     = 0;
      flags_checked     = 0;
      flags_set         = 0;
      settings_loaded   = 0;
      clear_search_state();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_payload_boundaries();
      test_register_corners();
      test_random_search();

      $display("covered %0d bytes in %0d payloads, %0d found flags checked (%0d set)",
               bytes_sent, payloads_sent, flags_checked, flags_set);
      $display("pattern settings loaded: %0d, mismatches: %0d", settings_loaded, fail_count);
      if (fail_count == 0 && expected_found.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/ppm_pkg.sv
hw/rtl/ppm_if.sv
hw/rtl/ppm_csr.sv
hw/rtl/ppm_scan.sv
hw/rtl/ppm_result.sv
hw/rtl/payload_pattern_matcher.sv
tb/tb_payload_pattern_matcher.sv
